/* src/kmc_pkg.sv */
`timescale 1ns / 1ps

package kmc_pkg;

    // datapath word and its bit counter
    localparam int WORD_W = 64;
    localparam int CNT_W  = 6;

    // defaults of the top-level parameters
    localparam int FRAC_DIGITS_DEF = 6;
    localparam int INT_WIDTH_DEF   = 32;
    localparam int DEC_CHARS_DEF   = 13;

    localparam int LEN_W    = 6;
    localparam int FCOUNT_W = 4;
    localparam int KEY_W    = 8;
    localparam int OUT_W    = 208;

    // keypad codes
    localparam logic [KEY_W-1:0] KEY_NONE  = 8'h00;
    localparam logic [KEY_W-1:0] KEY_P     = 8'h50;
    localparam logic [KEY_W-1:0] KEY_B     = 8'h42;
    localparam logic [KEY_W-1:0] KEY_O     = 8'h4F;
    localparam logic [KEY_W-1:0] KEY_H     = 8'h48;
    localparam logic [KEY_W-1:0] KEY_C     = 8'h43;
    localparam logic [KEY_W-1:0] KEY_PCT   = 8'h25;
    localparam logic [KEY_W-1:0] KEY_ADD   = 8'h2B;
    localparam logic [KEY_W-1:0] KEY_SUB   = 8'h2D;
    localparam logic [KEY_W-1:0] KEY_MUL   = 8'h2A;
    localparam logic [KEY_W-1:0] KEY_DIV   = 8'h44;
    localparam logic [KEY_W-1:0] KEY_EQ    = 8'h3D;
    localparam logic [KEY_W-1:0] KEY_POINT = 8'h2E;
    localparam logic [KEY_W-1:0] KEY_0     = 8'h30;
    localparam logic [KEY_W-1:0] KEY_9     = 8'h39;
    localparam logic [KEY_W-1:0] KEY_UA    = 8'h41;
    localparam logic [KEY_W-1:0] KEY_UF    = 8'h46;
    localparam logic [KEY_W-1:0] KEY_LA    = 8'h61;
    localparam logic [KEY_W-1:0] KEY_LF    = 8'h66;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_BIN = 2'd1,
        BASE_OCT = 2'd2,
        BASE_HEX = 2'd3
    } t_base;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAIT,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL,
        MD_CHK,
        MD_DIV,
        MD_DONE
    } t_md_state;

    // calculation state, cleared as one by clear, power-on and mode keys
    typedef struct packed {
        t_op                 op;
        logic                second;
        logic                shown;
        logic [WORD_W-1:0]   entry;
        logic [LEN_W-1:0]    len;
        logic                point;
        logic [FCOUNT_W-1:0] fcount;
        logic [WORD_W-1:0]   first;
        logic [WORD_W-1:0]   result;
    } t_calc;

    localparam t_calc CALC_CLEAR = '{
        op: OP_NONE, second: 1'b0, shown: 1'b0, entry: '0, len: 6'd1,
        point: 1'b0, fcount: '0, first: '0, result: '0
    };

    typedef struct packed {
        logic start;
        logic skip_mul;  // dividend is a itself
        logic skip_div;  // result is the low product word
    } t_md_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_md_stat;

    function automatic logic [WORD_W-1:0] pow10(input logic [4:0] n);
        logic [WORD_W-1:0] r;
        case (n)
            5'd0:    r = 64'd1;
            5'd1:    r = 64'd10;
            5'd2:    r = 64'd100;
            5'd3:    r = 64'd1000;
            5'd4:    r = 64'd10000;
            5'd5:    r = 64'd100000;
            5'd6:    r = 64'd1000000;
            5'd7:    r = 64'd10000000;
            5'd8:    r = 64'd100000000;
            5'd9:    r = 64'd1000000000;
            5'd10:   r = 64'd10000000000;
            5'd11:   r = 64'd100000000000;
            5'd12:   r = 64'd1000000000000;
            5'd13:   r = 64'd10000000000000;
            5'd14:   r = 64'd100000000000000;
            5'd15:   r = 64'd1000000000000000;
            5'd16:   r = 64'd10000000000000000;
            5'd17:   r = 64'd100000000000000000;
            5'd18:   r = 64'd1000000000000000000;
            5'd19:   r = 64'd10000000000000000000;
            default: r = 64'd0;
        endcase
        return r;
    endfunction

endpackage

/* src/kmc_muldiv.sv */
`timescale 1ns / 1ps

// Bit-serial (a*b)/d: 64 shift-add steps, then 64 restoring divide steps; either pass can be skipped.
module kmc_muldiv
    import kmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_md_req           i_req,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    input  logic [WORD_W-1:0] i_d,
    output t_md_stat          o_stat,
    output logic [WORD_W-1:0] o_result
);

    t_md_state         r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [WORD_W-1:0] r_hi, n_hi;
    logic [WORD_W-1:0] r_lo, n_lo;
    logic [WORD_W-1:0] r_a, n_a;
    logic [WORD_W-1:0] r_d, n_d;
    logic              r_skip_div, n_skip_div;
    logic [WORD_W-1:0] r_result, n_result;

    logic [WORD_W:0]   add_sum;
    logic [WORD_W-1:0] shl_rem;
    logic [WORD_W:0]   sub_rem;
    logic              sub_ok;

    assign add_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);
    assign shl_rem = {r_hi[WORD_W-2:0], r_lo[WORD_W-1]};
    assign sub_rem = {r_hi[WORD_W-1], shl_rem} - {1'b0, r_d};
    assign sub_ok  = r_hi[WORD_W-1] || (shl_rem >= r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt      <= n_cnt;
        r_hi       <= n_hi;
        r_lo       <= n_lo;
        r_a        <= n_a;
        r_d        <= n_d;
        r_skip_div <= n_skip_div;
        r_result   <= n_result;
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_hi       = r_hi;
        n_lo       = r_lo;
        n_a        = r_a;
        n_d        = r_d;
        n_skip_div = r_skip_div;
        n_result   = r_result;
        unique case (r_state)
            MD_IDLE: begin
                if (i_req.start) begin
                    n_a        = i_a;
                    n_d        = i_d;
                    n_hi       = '0;
                    n_lo       = i_req.skip_mul ? i_a : i_b;
                    n_cnt      = '0;
                    n_skip_div = i_req.skip_div;
                    n_state    = i_req.skip_mul ? MD_CHK : MD_MUL;
                end
            end
            MD_MUL: begin
                n_hi  = add_sum[WORD_W:1];
                n_lo  = {add_sum[0], r_lo[WORD_W-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_state = MD_CHK;
                end
            end
            MD_CHK: begin
                n_cnt = '0;
                if (r_skip_div) begin
                    n_result = r_lo;
                    n_state  = MD_DONE;
                end else if (r_hi >= r_d) begin
                    // quotient would not fit
                    n_result = '1;
                    n_state  = MD_DONE;
                end else begin
                    n_state = MD_DIV;
                end
            end
            MD_DIV: begin
                n_hi  = sub_ok ? sub_rem[WORD_W-1:0] : shl_rem;
                n_lo  = {r_lo[WORD_W-2:0], sub_ok};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_result = {r_lo[WORD_W-2:0], sub_ok};
                    n_state  = MD_DONE;
                end
            end
            MD_DONE: begin
                n_state = MD_IDLE;
            end
            default: begin
                n_state = MD_IDLE;
            end
        endcase
    end

    assign o_stat.busy = (r_state != MD_IDLE);
    assign o_stat.done = (r_state == MD_DONE);
    assign o_result    = r_result;

endmodule

/* src/keypad_multibase_calculator_unit.sv */
`timescale 1ns / 1ps
// Each key passes ST_IDLE, ST_EXEC and ST_EMIT into the output register; '=' after
//   '*' or 'D', and '%', add a bit-serial pass through ST_WAIT (up to 64 multiply
//   steps and 64 divide steps in kmc_muldiv). One key is in work at a time.
// A new key is taken while the previous result item waits on the output register.
// Reset (i_rst_n low, synchronous): power off, DEC mode, calculation cleared.
module keypad_multibase_calculator_unit
    import kmc_pkg::*;
#(
    parameter int DEC_FRACTION_DIGITS = FRAC_DIGITS_DEF,  // 0..6
    parameter int INT_MODE_WIDTH      = INT_WIDTH_DEF,    // 8..32
    parameter int DEC_MAX_CHARS       = DEC_CHARS_DEF     // 1..13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [KEY_W-1:0] i_s_axis_tdata,   // key_char
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // power_on, base_mode[2], pending_operator[3], second_entry_active,
    // result_shown, entry_number[64], entry_chars[6], entry_has_point,
    // first_operand[64], result_number[64], one zero pad bit
    output logic [OUT_W-1:0] o_m_axis_tdata
);

    localparam logic [WORD_W-1:0] INT_MASK = (64'd1 << INT_MODE_WIDTH) - 64'd1;
    localparam logic [WORD_W-1:0] SCALE    = pow10(5'(DEC_FRACTION_DIGITS));
    localparam logic [WORD_W-1:0] PCT_DIV  = SCALE * 64'd100;
    localparam logic [LEN_W-1:0]  MAX_DEC  = LEN_W'(DEC_MAX_CHARS);
    localparam logic [LEN_W-1:0]  MAX_BIN  = LEN_W'(INT_MODE_WIDTH);
    localparam logic [LEN_W-1:0]  MAX_OCT  = LEN_W'((INT_MODE_WIDTH + 2) / 3);
    localparam logic [LEN_W-1:0]  MAX_HEX  = LEN_W'((INT_MODE_WIDTH + 3) / 4);
    localparam logic [4:0]        FRAC_TOP = 5'(DEC_FRACTION_DIGITS - 1);
    localparam logic [FCOUNT_W-1:0] FRAC_N = FCOUNT_W'(DEC_FRACTION_DIGITS);

    // control and machine state
    t_state             r_state, n_state;
    logic               r_power, n_power;
    t_base              r_base, n_base;
    t_calc              r_calc, n_calc;
    logic [KEY_W-1:0]   r_key, n_key;
    logic               r_out_valid, n_out_valid;
    logic [OUT_W-1:0]   r_out_data, n_out_data;

    // serial multiply/divide
    t_md_req            md_req;
    t_md_stat           md_stat;
    logic [WORD_W-1:0]  md_a, md_b, md_d, md_result;

    // key decode
    logic               is_dec;
    logic [3:0]         dig;
    logic               dig_ok;
    logic               is_point;
    logic               key_ok;
    logic [WORD_W-1:0]  d64;
    logic [LEN_W-1:0]   max_len;
    t_base              mode_sel;

    // entry and add/sub arithmetic
    logic [WORD_W-1:0]  dec_start;
    logic [WORD_W-1:0]  start_val;
    logic [WORD_W+3:0]  int_shift;
    logic [WORD_W+3:0]  int_wide;
    logic [WORD_W-1:0]  int_app;
    logic [WORD_W+3:0]  dec_wide;
    logic [WORD_W-1:0]  dec_app;
    logic [WORD_W-1:0]  frac_add;
    logic [WORD_W:0]    frac_sum;
    logic [WORD_W-1:0]  frac_app;
    logic [WORD_W:0]    add_sum;
    logic [WORD_W-1:0]  add_res;
    logic [WORD_W-1:0]  sub_res;
    logic               just_zero;

    kmc_muldiv u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (md_req),
        .i_a      (md_a),
        .i_b      (md_b),
        .i_d      (md_d),
        .o_stat   (md_stat),
        .o_result (md_result)
    );

    // ---------------- key decode ----------------
    assign is_dec   = (r_base == BASE_DEC);
    assign is_point = (r_key == KEY_POINT);

    always_comb begin
        dig    = 4'd0;
        dig_ok = 1'b0;
        if (r_key >= KEY_0 && r_key <= KEY_9) begin
            dig    = 4'(r_key - KEY_0);
            dig_ok = 1'b1;
        end else if (r_base == BASE_HEX && r_key >= KEY_UA && r_key <= KEY_UF) begin
            dig    = 4'(r_key - KEY_UA + 8'd10);
            dig_ok = 1'b1;
        end else if (r_base == BASE_HEX && r_key >= KEY_LA && r_key <= KEY_LF) begin
            dig    = 4'(r_key - KEY_LA + 8'd10);
            dig_ok = 1'b1;
        end
        if (r_base == BASE_BIN && dig > 4'd1) begin
            dig_ok = 1'b0;
        end
        if (r_base == BASE_OCT && dig > 4'd7) begin
            dig_ok = 1'b0;
        end
    end

    assign key_ok = is_point ? (is_dec && !r_calc.point) : dig_ok;
    assign d64    = {{(WORD_W-4){1'b0}}, dig};

    always_comb begin
        unique case (r_base)
            BASE_BIN: begin
                max_len   = MAX_BIN;
                int_shift = {4'b0, r_calc.entry} << 1;
            end
            BASE_OCT: begin
                max_len   = MAX_OCT;
                int_shift = {4'b0, r_calc.entry} << 3;
            end
            BASE_HEX: begin
                max_len   = MAX_HEX;
                int_shift = {4'b0, r_calc.entry} << 4;
            end
            default: begin
                max_len   = MAX_DEC;
                int_shift = {4'b0, r_calc.entry} << 4;
            end
        endcase
    end

    always_comb begin
        unique case (r_key)
            KEY_B:   mode_sel = BASE_BIN;
            KEY_O:   mode_sel = BASE_OCT;
            default: mode_sel = BASE_HEX;
        endcase
    end

    // ---------------- entry arithmetic ----------------
    assign dec_start = d64 * SCALE;
    assign start_val = is_dec ? dec_start : (d64 & INT_MASK);

    // integer append saturates at the mode mask
    assign int_wide = int_shift + {4'b0, d64};
    assign int_app  = (int_wide > {4'b0, INT_MASK}) ? INT_MASK : int_wide[WORD_W-1:0];

    // whole DEC digit: v*10 + d*scale, saturating at all ones
    assign dec_wide = ({4'b0, r_calc.entry} << 3) + ({4'b0, r_calc.entry} << 1)
                    + {4'b0, dec_start};
    assign dec_app  = (dec_wide[WORD_W+3:WORD_W] != 4'd0) ? '1 : dec_wide[WORD_W-1:0];

    // fraction digit weight falls by ten per digit
    assign frac_add = d64 * pow10(FRAC_TOP - {1'b0, r_calc.fcount});
    assign frac_sum = {1'b0, r_calc.entry} + {1'b0, frac_add};
    assign frac_app = frac_sum[WORD_W] ? '1 : frac_sum[WORD_W-1:0];

    assign just_zero = (r_calc.len == LEN_W'(1)) && !r_calc.point && (r_calc.entry == '0);

    // add saturates in DEC, wraps in integer modes; subtract clamps at zero
    assign add_sum = {1'b0, r_calc.first} + {1'b0, r_calc.entry};
    assign add_res = is_dec ? (add_sum[WORD_W] ? '1 : add_sum[WORD_W-1:0])
                            : (add_sum[WORD_W-1:0] & INT_MASK);
    assign sub_res = (r_calc.first >= r_calc.entry) ? (r_calc.first - r_calc.entry) : '0;

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_power     <= 1'b0;
            r_base      <= BASE_DEC;
            r_calc      <= CALC_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_power     <= n_power;
            r_base      <= n_base;
            r_calc      <= n_calc;
            r_out_valid <= n_out_valid;
        end
        r_key      <= n_key;
        r_out_data <= n_out_data;
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_power     = r_power;
        n_base      = r_base;
        n_calc      = r_calc;
        n_key       = r_key;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        md_req      = '0;
        md_a        = r_calc.first;
        md_b        = r_calc.entry;
        md_d        = SCALE;

        unique case (r_state)
            ST_IDLE: begin
                // a null key is consumed without a result item
                if (i_s_axis_tvalid && i_s_axis_tdata != KEY_NONE) begin
                    n_key   = i_s_axis_tdata;
                    n_state = ST_EXEC;
                end
            end

            ST_EXEC: begin
                n_state = ST_EMIT;
                if (r_key == KEY_P) begin
                    n_power = !r_power;
                    if (!r_power) begin
                        n_calc = CALC_CLEAR;
                    end
                end else if (r_power) begin
                    unique case (r_key) inside
                        KEY_B, KEY_O, KEY_H: begin
                            n_base = (r_base == mode_sel) ? BASE_DEC : mode_sel;
                            n_calc = CALC_CLEAR;
                        end
                        KEY_C: begin
                            n_calc = CALC_CLEAR;
                        end
                        KEY_PCT: begin
                            if (is_dec && r_calc.second && r_calc.op != OP_NONE) begin
                                md_req.start = 1'b1;
                                md_d         = PCT_DIV;
                                n_state      = ST_WAIT;
                            end
                        end
                        KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV: begin
                            n_calc.first  = r_calc.shown ? r_calc.result : r_calc.entry;
                            n_calc.shown  = 1'b0;
                            n_calc.second = 1'b1;
                            n_calc.entry  = '0;
                            n_calc.len    = LEN_W'(1);
                            n_calc.point  = 1'b0;
                            n_calc.fcount = '0;
                            unique case (r_key) inside
                                KEY_ADD: n_calc.op = OP_ADD;
                                KEY_SUB: n_calc.op = OP_SUB;
                                KEY_MUL: n_calc.op = OP_MUL;
                                default: n_calc.op = OP_DIV;
                            endcase
                        end
                        KEY_EQ: begin
                            if (r_calc.op != OP_NONE && r_calc.second) begin
                                unique case (r_calc.op)
                                    OP_ADD: begin
                                        n_calc.result = add_res;
                                        n_calc.shown  = 1'b1;
                                    end
                                    OP_SUB: begin
                                        n_calc.result = sub_res;
                                        n_calc.shown  = 1'b1;
                                    end
                                    OP_MUL: begin
                                        // integer product wraps, so skip the divide
                                        md_req.start    = 1'b1;
                                        md_req.skip_div = !is_dec;
                                        n_state         = ST_WAIT;
                                    end
                                    OP_DIV: begin
                                        if (r_calc.entry == '0) begin
                                            n_calc.result = '0;
                                            n_calc.shown  = 1'b1;
                                        end else begin
                                            // DEC: a*scale/b; integer: a/b
                                            md_req.start    = 1'b1;
                                            md_req.skip_mul = !is_dec;
                                            md_b            = SCALE;
                                            md_d            = r_calc.entry;
                                            n_state         = ST_WAIT;
                                        end
                                    end
                                    default: begin
                                        n_state = ST_EMIT;
                                    end
                                endcase
                            end
                        end
                        default: begin
                            if (key_ok && r_calc.shown) begin
                                // new entry after a result starts from clear
                                n_calc = CALC_CLEAR;
                                if (is_point) begin
                                    n_calc.point = 1'b1;
                                end else begin
                                    n_calc.entry = start_val;
                                end
                            end else if (key_ok) begin
                                if (just_zero && !is_point && !(!is_dec && dig == 4'd0)) begin
                                    n_calc.entry = start_val;
                                    n_calc.len   = LEN_W'(1);
                                end else if (r_calc.len < max_len) begin
                                    n_calc.len = r_calc.len + 1'b1;
                                    if (is_point) begin
                                        n_calc.point = 1'b1;
                                    end else if (!is_dec) begin
                                        n_calc.entry = int_app;
                                    end else if (!r_calc.point) begin
                                        n_calc.entry = dec_app;
                                    end else if (r_calc.fcount < FRAC_N) begin
                                        // digits past the last fraction place are dropped
                                        n_calc.entry  = frac_app;
                                        n_calc.fcount = r_calc.fcount + 1'b1;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end

            ST_WAIT: begin
                if (md_stat.done) begin
                    n_calc.result = is_dec ? md_result : (md_result & INT_MASK);
                    n_calc.shown  = 1'b1;
                    n_state       = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, r_calc.result, r_calc.first, r_calc.point,
                                   r_calc.len, r_calc.entry, r_calc.shown,
                                   r_calc.second, r_calc.op, r_base, r_power};
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ---------------- checks ----------------
    a_md_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_stat.done |-> (r_state == ST_WAIT))
        else $error("muldiv finished outside wait state");

    a_md_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_req.start |-> !md_stat.busy)
        else $error("muldiv started while busy");

    a_int_entry_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_base != BASE_DEC) |-> (r_calc.entry <= INT_MASK))
        else $error("integer entry beyond mode width");

    a_frac_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_calc.fcount <= FRAC_N) && (r_calc.len != '0))
        else $error("entry length or fraction count out of range");

endmodule
